### rtl/core/ddagw_pkg.sv
// Shared types and constants of the DDA grid ray walker.
package ddagw_pkg;

	localparam int MAP_W   = 64;
	localparam int MAP_H   = 64;
	localparam int COL_W   = $clog2(MAP_W);
	localparam int ROW_W   = $clog2(MAP_H);
	localparam int CELL_W  = 6;
	localparam int COORD_W = 8;
	localparam int LIM_W   = 7;
	localparam int Q_W     = 32;
	localparam int S_DATA_W = 144;
	localparam int M_DATA_W = 88;

	localparam logic CMD_WRITE = 1'b0;
	localparam logic CMD_CAST  = 1'b1;

	localparam logic [1:0] OUT_WRITTEN = 2'd0;
	localparam logic [1:0] OUT_WALL    = 2'd1;
	localparam logic [1:0] OUT_LEFT    = 2'd2;

	localparam logic REG_MAP_ROWS = 1'b0;
	localparam logic REG_MAP_COLS = 1'b1;

	typedef struct packed {
		logic load;
		logic advance;
	} walk_ctrl_t;

	typedef struct packed {
		logic             en;
		logic [ROW_W-1:0] row;
		logic [COL_W-1:0] col;
		logic             wall;
	} map_wr_t;

endpackage

### rtl/core/ddagw_map.sv
// Wall map memory: one row per word, cleared row by row after reset.
module ddagw_map (
	input  logic                          clk,
	input  logic                          arst_n,
	input  ddagw_pkg::map_wr_t            wr,
	input  logic [ddagw_pkg::ROW_W-1:0]   rd_row,
	input  logic [ddagw_pkg::COL_W-1:0]   rd_col,
	output logic                          rd_wall,
	output logic                          busy
);
	import ddagw_pkg::*;

	logic [MAP_W-1:0] wall_mem_q [MAP_H];
	logic [MAP_W-1:0] rd_data_q;
	logic [COL_W-1:0] rd_col_q;
	logic [ROW_W-1:0] clr_row_q;
	logic             busy_q;

	// Sweep every row to open once after reset.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q    <= 1'b1;
			clr_row_q <= '0;
		end else if (busy_q) begin
			clr_row_q <= clr_row_q + 1'b1;
			if (clr_row_q == ROW_W'(MAP_H - 1)) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (busy_q) begin
			wall_mem_q[clr_row_q] <= '0;
		end else if (wr.en) begin
			wall_mem_q[wr.row][wr.col] <= wr.wall;
		end
	end

	always_ff @(posedge clk) begin
		rd_data_q <= wall_mem_q[rd_row];
		rd_col_q  <= rd_col;
	end

	assign rd_wall = rd_data_q[rd_col_q];
	assign busy    = busy_q;

endmodule

### rtl/core/ddagw_walk.sv
// Walk datapath: shared compare and saturating adder, cell and side registers.
module ddagw_walk (
	input  logic                                clk,
	input  ddagw_pkg::walk_ctrl_t               ctrl,
	input  logic [ddagw_pkg::CELL_W-1:0]        start_x,
	input  logic [ddagw_pkg::CELL_W-1:0]        start_y,
	input  logic                                neg_x,
	input  logic                                neg_y,
	input  logic [ddagw_pkg::Q_W-1:0]           delta_x,
	input  logic [ddagw_pkg::Q_W-1:0]           delta_y,
	input  logic [ddagw_pkg::Q_W-1:0]           side_x0,
	input  logic [ddagw_pkg::Q_W-1:0]           side_y0,
	output logic signed [ddagw_pkg::COORD_W-1:0] x,
	output logic signed [ddagw_pkg::COORD_W-1:0] y,
	output logic signed [ddagw_pkg::COORD_W-1:0] nxt_x,
	output logic signed [ddagw_pkg::COORD_W-1:0] nxt_y,
	output logic                                side,
	output logic [ddagw_pkg::Q_W-1:0]           side_x,
	output logic [ddagw_pkg::Q_W-1:0]           side_y
);
	import ddagw_pkg::*;

	logic signed [COORD_W-1:0] x_q, y_q;
	logic [Q_W-1:0]            side_x_q, side_y_q, dx_q, dy_q;
	logic                      neg_x_q, neg_y_q, side_q;
	logic                      take_x;
	logic [Q_W-1:0]            add_a, add_b, sat_sum;
	logic [Q_W:0]              sum;

	// Smaller side distance steps; a tie goes to the row side.
	always_comb begin
		take_x  = side_x_q < side_y_q;
		add_a   = take_x ? side_x_q : side_y_q;
		add_b   = take_x ? dx_q : dy_q;
		sum     = {1'b0, add_a} + {1'b0, add_b};
		sat_sum = sum[Q_W] ? '1 : sum[Q_W-1:0];
		nxt_x   = x_q;
		nxt_y   = y_q;
		if (take_x) begin
			nxt_x = neg_x_q ? x_q - COORD_W'(1) : x_q + COORD_W'(1);
		end else begin
			nxt_y = neg_y_q ? y_q - COORD_W'(1) : y_q + COORD_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.load) begin
			x_q      <= COORD_W'(start_x);
			y_q      <= COORD_W'(start_y);
			neg_x_q  <= neg_x;
			neg_y_q  <= neg_y;
			dx_q     <= delta_x;
			dy_q     <= delta_y;
			side_x_q <= side_x0;
			side_y_q <= side_y0;
			side_q   <= 1'b0;
		end else if (ctrl.advance) begin
			x_q    <= nxt_x;
			y_q    <= nxt_y;
			side_q <= !take_x;
			if (take_x) begin
				side_x_q <= sat_sum;
			end else begin
				side_y_q <= sat_sum;
			end
		end
	end

	assign x      = x_q;
	assign y      = y_q;
	assign side   = side_q;
	assign side_x = side_x_q;
	assign side_y = side_y_q;

endmodule

### rtl/core/dda_grid_ray_walker.sv
// DDA grid ray walker: wall map, walk sequencer and result register.
//
// A write item stores one map cell and goes straight to ST_FINISH, where its
// result is registered. A cast item walks the grid cell by cell: ST_STEP does
// the shared compare and saturating add that picks and advances a side
// distance, ST_LOOK the registered wall map read of the new cell. A walk
// enters at most MAP_W + MAP_H - 1 cells; a previous result still waiting on
// m_tready holds the new one back until it is taken. One item is in work at a
// time. After reset the map is cleared one row per cycle; no item is accepted
// meanwhile, while configuration writes are taken at any time.
module dda_grid_ray_walker (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_we,
	input  logic                             cfg_index,
	input  logic [ddagw_pkg::LIM_W-1:0]      cfg_data,
	input  logic                             s_tvalid,
	output logic                             s_tready,
	// command
	input  logic                             s_tuser,
	// cell_x, cell_y, cell_is_wall, step_x_negative, step_y_negative,
	// step_dist_x, step_dist_y, start_side_x, start_side_y, zero pad
	input  logic [ddagw_pkg::S_DATA_W-1:0]   s_tdata,
	output logic                             m_tvalid,
	input  logic                             m_tready,
	// outcome
	output logic [1:0]                       m_tuser,
	// end_x, end_y, hit_side, final_side_x, final_side_y, zero pad
	output logic [ddagw_pkg::M_DATA_W-1:0]   m_tdata
);
	import ddagw_pkg::*;

	localparam logic [1:0] ST_IDLE   = 2'd0;
	localparam logic [1:0] ST_STEP   = 2'd1;
	localparam logic [1:0] ST_LOOK   = 2'd2;
	localparam logic [1:0] ST_FINISH = 2'd3;

	logic [1:0]          state_q;
	logic [LIM_W-1:0]    map_rows_q, map_cols_q, rows_lim, cols_lim;
	logic                cmd_q;
	logic [1:0]          outcome_q;
	logic                m_tvalid_q;
	logic [1:0]          m_tuser_q;
	logic [M_DATA_W-1:0] m_tdata_q;

	logic [CELL_W-1:0]   in_x, in_y;
	logic                in_wall, in_neg_x, in_neg_y;
	logic [Q_W-1:0]      in_dx, in_dy, in_sx, in_sy;
	logic                accept, map_busy, rd_wall, out_free, off_map;

	walk_ctrl_t          ctrl;
	map_wr_t             wr;

	logic signed [COORD_W-1:0] x, y, nxt_x, nxt_y;
	logic                      side;
	logic [Q_W-1:0]            side_x, side_y;

	assign in_x     = s_tdata[5:0];
	assign in_y     = s_tdata[11:6];
	assign in_wall  = s_tdata[12];
	assign in_neg_x = s_tdata[13];
	assign in_neg_y = s_tdata[14];
	assign in_dx    = s_tdata[46:15];
	assign in_dy    = s_tdata[78:47];
	assign in_sx    = s_tdata[110:79];
	assign in_sy    = s_tdata[142:111];

	assign s_tready = (state_q == ST_IDLE) && !map_busy;
	assign accept   = s_tvalid && s_tready;
	assign out_free = !m_tvalid_q || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			map_rows_q <= LIM_W'(64);
			map_cols_q <= LIM_W'(64);
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_MAP_ROWS: map_rows_q <= cfg_data;
				REG_MAP_COLS: map_cols_q <= cfg_data;
				default:      map_rows_q <= map_rows_q;
			endcase
		end
	end

	assign rows_lim = (32'(map_rows_q) > MAP_H) ? LIM_W'(MAP_H) : map_rows_q;
	assign cols_lim = (32'(map_cols_q) > MAP_W) ? LIM_W'(MAP_W) : map_cols_q;

	assign ctrl.load    = accept && (s_tuser == CMD_CAST);
	assign ctrl.advance = (state_q == ST_STEP);

	always_comb begin
		wr.en   = accept && (s_tuser == CMD_WRITE)
			&& (32'(in_x) < MAP_W) && (32'(in_y) < MAP_H);
		wr.row  = in_y[ROW_W-1:0];
		wr.col  = in_x[COL_W-1:0];
		wr.wall = in_wall;
	end

	ddagw_walk u_walk (
		.clk     (clk),
		.ctrl    (ctrl),
		.start_x (in_x),
		.start_y (in_y),
		.neg_x   (in_neg_x),
		.neg_y   (in_neg_y),
		.delta_x (in_dx),
		.delta_y (in_dy),
		.side_x0 (in_sx),
		.side_y0 (in_sy),
		.x       (x),
		.y       (y),
		.nxt_x   (nxt_x),
		.nxt_y   (nxt_y),
		.side    (side),
		.side_x  (side_x),
		.side_y  (side_y)
	);

	// Read the cell being entered; an off-map read is ignored.
	ddagw_map u_map (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr      (wr),
		.rd_row  (nxt_y[ROW_W-1:0]),
		.rd_col  (nxt_x[COL_W-1:0]),
		.rd_wall (rd_wall),
		.busy    (map_busy)
	);

	assign off_map = x[COORD_W-1] || y[COORD_W-1]
		|| (x[LIM_W-1:0] >= cols_lim) || (y[LIM_W-1:0] >= rows_lim);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						state_q <= (s_tuser == CMD_CAST) ? ST_STEP : ST_FINISH;
					end
				end
				ST_STEP: state_q <= ST_LOOK;
				ST_LOOK: begin
					if (off_map || rd_wall) begin
						state_q <= ST_FINISH;
					end else begin
						state_q <= ST_STEP;
					end
				end
				ST_FINISH: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_q     <= s_tuser;
			outcome_q <= OUT_WRITTEN;
		end else if (state_q == ST_LOOK) begin
			outcome_q <= off_map ? OUT_LEFT : OUT_WALL;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (state_q == ST_FINISH && out_free) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	// Load the result; a write reports all fields as zero.
	always_ff @(posedge clk) begin
		if (state_q == ST_FINISH && out_free) begin
			m_tuser_q <= outcome_q;
			if (cmd_q == CMD_CAST) begin
				m_tdata_q <= {7'd0, side_y, side_x, side, y, x};
			end else begin
				m_tdata_q <= '0;
			end
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tuser  = m_tuser_q;
	assign m_tdata  = m_tdata_q;

`ifndef SYNTHESIS
	a_one_axis_per_step: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_STEP |=> ((x != $past(x)) != (y != $past(y))))
		else $error("walk step moved zero or two coordinates");

	a_result_from_finish: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> $past(state_q == ST_FINISH))
		else $error("result raised outside the finish state");

	a_no_accept_in_walk: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_STEP || state_q == ST_LOOK) |-> !s_tready)
		else $error("input ready during a walk");
`endif

endmodule

### sim/tb_top.sv
// Self-checking testbench for the DDA grid ray walker: map writes, ray casts, map size registers.
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	import ddagw_pkg::*;

	localparam int CYCLE_LIMIT  = 1000000;
	localparam int DRAIN_CYCLES = 300;
	localparam int PHASE_ITEMS  = 58;
	localparam logic [31:0] Q_ONE  = 32'h0001_0000;
	localparam logic [31:0] Q_HALF = 32'h0000_8000;
	localparam logic [31:0] Q_SAT  = 32'hFFFF_FFFF;

	typedef struct packed {
		logic        cmd;
		logic [5:0]  cell_x;
		logic [5:0]  cell_y;
		logic        is_wall;
		logic        neg_x;
		logic        neg_y;
		logic [31:0] delta_x;
		logic [31:0] delta_y;
		logic [31:0] side_x;
		logic [31:0] side_y;
	} ray_cmd_t;

	typedef struct packed {
		logic [1:0]  outcome;
		logic [7:0]  end_x;
		logic [7:0]  end_y;
		logic        hit_side;
		logic [31:0] side_x;
		logic [31:0] side_y;
	} walk_result_t;

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                cfg_we = 1'b0;
	logic                cfg_index = 1'b0;
	logic [LIM_W-1:0]    cfg_data = '0;
	logic                s_tvalid = 1'b0;
	logic                s_tready;
	logic                s_tuser = 1'b0;
	logic [S_DATA_W-1:0] s_tdata = '0;
	logic                m_tvalid;
	logic                m_tready = 1'b0;
	logic [1:0]          m_tuser;
	logic [M_DATA_W-1:0] m_tdata;

	// predictor state
	bit               wall_bits [MAP_H][MAP_W];
	logic [LIM_W-1:0] rows_reg = 7'd64;
	logic [LIM_W-1:0] cols_reg = 7'd64;

	ray_cmd_t     pending_cmds[$];
	walk_result_t expected_walks[$];
	ray_cmd_t     cur_cmd;

	int items_sent = 0;
	int results_seen = 0;
	int err_count = 0;
	int cycle_count = 0;
	int idle_pct = 8;
	int n_writes = 0;
	int n_hits = 0;
	int n_left = 0;
	int n_settings = 0;

	dda_grid_ray_walker i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tuser   (s_tuser),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tuser   (m_tuser),
		.m_tdata   (m_tdata)
	);

	initial begin
		forever #6 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("Timeout after %0d cycles, %0d of %0d results seen",
				cycle_count, results_seen, items_sent);
			$display("FAIL dda_grid_ray_walker");
			$finish;
		end
	end

	function automatic logic [31:0] sat_sum(logic [31:0] a, logic [31:0] b);
		logic [32:0] s;
		s = {1'b0, a} + {1'b0, b};
		return s[32] ? Q_SAT : s[31:0];
	endfunction

	// Apply a write to the map, or walk a ray against the current map and limits.
	function automatic walk_result_t trace_ray(ray_cmd_t c);
		walk_result_t r;
		int x, y, rows, cols;
		logic [31:0] sdx, sdy;
		bit done;
		r = '0;
		if (c.cmd == CMD_WRITE) begin
			wall_bits[c.cell_y][c.cell_x] = c.is_wall;
			r.outcome = OUT_WRITTEN;
			n_writes++;
			return r;
		end
		rows = (rows_reg > MAP_H) ? MAP_H : int'(rows_reg);
		cols = (cols_reg > MAP_W) ? MAP_W : int'(cols_reg);
		x = c.cell_x;
		y = c.cell_y;
		sdx = c.side_x;
		sdy = c.side_y;
		done = 1'b0;
		// the start cell is never tested
		while (!done) begin
			if (sdx < sdy) begin
				sdx = sat_sum(sdx, c.delta_x);
				x += c.neg_x ? -1 : 1;
				r.hit_side = 1'b0;
			end else begin
				sdy = sat_sum(sdy, c.delta_y);
				y += c.neg_y ? -1 : 1;
				r.hit_side = 1'b1;
			end
			if (x < 0 || y < 0 || y >= rows || x >= cols) begin
				r.outcome = OUT_LEFT;
				done = 1'b1;
			end else if (wall_bits[y][x]) begin
				r.outcome = OUT_WALL;
				done = 1'b1;
			end
		end
		r.end_x = 8'(x);
		r.end_y = 8'(y);
		r.side_x = sdx;
		r.side_y = sdy;
		if (r.outcome == OUT_WALL)
			n_hits++;
		else
			n_left++;
		return r;
	endfunction

	// driver
	always @(posedge clk) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
		end else begin
			if (s_tvalid && s_tready)
				expected_walks.push_back(trace_ray(cur_cmd));
			if (!s_tvalid || s_tready) begin
				if (pending_cmds.size() != 0 && $urandom_range(99) >= idle_pct) begin
					cur_cmd = pending_cmds.pop_front();
					s_tvalid <= 1'b1;
					s_tuser  <= cur_cmd.cmd;
					s_tdata  <= {1'b0, cur_cmd.side_y, cur_cmd.side_x, cur_cmd.delta_y,
						cur_cmd.delta_x, cur_cmd.neg_y, cur_cmd.neg_x, cur_cmd.is_wall,
						cur_cmd.cell_y, cur_cmd.cell_x};
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	task automatic report_field(string name, logic [31:0] want, logic [31:0] got);
		$display("%0t: %s mismatch, expected %h, got %h", $time, name, want, got);
		err_count++;
	endtask

	// monitor
	always @(posedge clk) begin : monitor
		walk_result_t got, want;
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else begin
			if (m_tvalid && m_tready) begin
				results_seen++;
				got.outcome  = m_tuser;
				got.end_x    = m_tdata[7:0];
				got.end_y    = m_tdata[15:8];
				got.hit_side = m_tdata[16];
				got.side_x   = m_tdata[48:17];
				got.side_y   = m_tdata[80:49];
				if (expected_walks.size() == 0) begin
					$display("%0t: unexpected result, expected none, got %h", $time, got);
					err_count++;
				end else begin
					want = expected_walks.pop_front();
					if (got.outcome !== want.outcome)
						report_field("outcome", 32'(want.outcome), 32'(got.outcome));
					if (got.end_x !== want.end_x)
						report_field("end_x", 32'(want.end_x), 32'(got.end_x));
					if (got.end_y !== want.end_y)
						report_field("end_y", 32'(want.end_y), 32'(got.end_y));
					if (got.hit_side !== want.hit_side)
						report_field("hit_side", 32'(want.hit_side), 32'(got.hit_side));
					if (got.side_x !== want.side_x)
						report_field("final_side_x", want.side_x, got.side_x);
					if (got.side_y !== want.side_y)
						report_field("final_side_y", want.side_y, got.side_y);
				end
			end
			m_tready <= ($urandom_range(99) >= idle_pct);
		end
	end

	task automatic send(ray_cmd_t c);
		pending_cmds.push_back(c);
		items_sent++;
	endtask

	function automatic ray_cmd_t map_write(int x, int y, bit wall);
		ray_cmd_t c;
		c = '0;
		c.cmd = CMD_WRITE;
		c.cell_x = 6'(x);
		c.cell_y = 6'(y);
		c.is_wall = wall;
		return c;
	endfunction

	function automatic ray_cmd_t ray(int x, int y, bit nx, bit ny,
			logic [31:0] dx, logic [31:0] dy, logic [31:0] sx, logic [31:0] sy);
		ray_cmd_t c;
		c = '0;
		c.cmd = CMD_CAST;
		c.cell_x = 6'(x);
		c.cell_y = 6'(y);
		c.neg_x = nx;
		c.neg_y = ny;
		c.delta_x = dx;
		c.delta_y = dy;
		c.side_x = sx;
		c.side_y = sy;
		return c;
	endfunction

	function automatic logic [31:0] random_q();
		case ($urandom_range(9))
			0: return $urandom;
			1: return '0;
			2: return Q_SAT;
			default: return $urandom_range(32'h0008_0000, 32'h0000_1000);
		endcase
	endfunction

	// Mostly well-formed items inside the map area in use, with some fully random noise.
	function automatic ray_cmd_t random_item(int rows, int cols);
		ray_cmd_t c;
		int span_x, span_y;
		logic [159:0] noise;
		span_x = (cols < 1) ? 1 : ((cols > MAP_W) ? MAP_W : cols);
		span_y = (rows < 1) ? 1 : ((rows > MAP_H) ? MAP_H : rows);
		if ($urandom_range(9) == 0) begin
			noise = {$urandom, $urandom, $urandom, $urandom, $urandom};
			c = noise[142:0];
			return c;
		end
		c.cmd = ($urandom_range(99) < 60) ? CMD_CAST : CMD_WRITE;
		c.cell_x = 6'($urandom_range(span_x - 1));
		c.cell_y = 6'($urandom_range(span_y - 1));
		c.is_wall = ($urandom_range(99) < 65);
		c.neg_x = 1'($urandom_range(1));
		c.neg_y = 1'($urandom_range(1));
		c.delta_x = random_q();
		c.delta_y = random_q();
		c.side_x = ($urandom_range(3) == 0) ? $urandom : $urandom_range(32'h0002_0000);
		c.side_y = ($urandom_range(3) == 0) ? $urandom : $urandom_range(32'h0002_0000);
		return c;
	endfunction

	task automatic wait_idle();
		do @(posedge clk); while (results_seen < items_sent);
	endtask

	// Write both limits; the block is idle whenever this is called.
	task automatic set_limits(logic [LIM_W-1:0] rows, logic [LIM_W-1:0] cols);
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= REG_MAP_ROWS;
		cfg_data  <= rows;
		@(posedge clk);
		cfg_index <= REG_MAP_COLS;
		cfg_data  <= cols;
		@(posedge clk);
		cfg_we <= 1'b0;
		rows_reg = rows;
		cols_reg = cols;
		n_settings++;
	endtask

	task automatic random_phase(int rows, int cols, bit hold_mid);
		set_limits(7'(rows), 7'(cols));
		for (int i = 0; i < PHASE_ITEMS; i++) begin
			send(random_item(rows, cols));
			// hold the sender until everything in flight has drained
			if (hold_mid && i == PHASE_ITEMS / 2)
				wait_idle();
		end
		wait_idle();
	endtask

	initial begin
		int phase_rows[8];
		int phase_cols[8];
		phase_rows = '{64, 8, 16, 1, 64, 127, 0, 12};
		phase_cols = '{64, 8, 5, 64, 1, 127, 12, 0};

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		// directed part with the reset limits of 64 by 64
		send(map_write(0, 0, 1'b1));
		send(map_write(63, 63, 1'b1));
		send(map_write(5, 3, 1'b1));
		send(ray(1, 0, 1'b1, 1'b0, Q_ONE, Q_ONE, Q_HALF, Q_ONE));
		send(ray(63, 62, 1'b0, 1'b0, Q_ONE, Q_ONE, Q_SAT, 32'h0));
		// zero deltas with equal sides: the row side wins every tie
		send(ray(5, 0, 1'b0, 1'b0, 32'h0, 32'h0, Q_SAT, Q_SAT));
		send(ray(10, 10, 1'b0, 1'b0, Q_ONE, Q_ONE, Q_ONE, Q_ONE));
		send(ray(2, 20, 1'b1, 1'b0, 32'h1000, Q_ONE, 32'h0, Q_SAT));
		send(ray(20, 2, 1'b0, 1'b1, Q_ONE, 32'h1000, Q_SAT, 32'h0));
		send(ray(20, 60, 1'b0, 1'b0, Q_SAT, 32'h100, Q_SAT, 32'h0));
		send(ray(60, 20, 1'b0, 1'b0, 32'h100, Q_SAT, 32'h0, Q_SAT));
		// both side distances saturate
		send(ray(30, 30, 1'b0, 1'b1, Q_SAT, Q_SAT, 32'h8000_0000, 32'hFFFF_0000));
		send(map_write(5, 3, 1'b0));
		send(ray(5, 0, 1'b0, 1'b0, 32'h0, 32'h0, Q_SAT, Q_SAT));
		wait_idle();
		// zero rows: first step leaves; oversize columns clamp to the map
		set_limits(7'd0, 7'd127);
		send(ray(7, 7, 1'b0, 1'b0, Q_ONE, Q_ONE, Q_ONE, Q_HALF));
		send(map_write(63, 0, 1'b1));
		send(ray(62, 0, 1'b0, 1'b0, Q_ONE, Q_ONE, 32'h0, Q_ONE));
		wait_idle();
		set_limits(7'd127, 7'd0);
		send(ray(0, 63, 1'b1, 1'b1, Q_ONE, Q_ONE, Q_HALF, Q_ONE));
		wait_idle();
		set_limits(7'd1, 7'd1);
		send(ray(0, 0, 1'b0, 1'b0, Q_ONE, Q_ONE, Q_HALF, 32'h9000));
		wait_idle();

		// random part, one stretch without any idling
		idle_pct = 0;
		random_phase(64, 64, 1'b0);
		idle_pct = 8;
		for (int p = 1; p < 8; p++)
			random_phase(phase_rows[p], phase_cols[p], p == 3);
		random_phase($urandom_range(64, 1), $urandom_range(64, 1), 1'b0);
		random_phase($urandom_range(64, 1), $urandom_range(64, 1), 1'b0);

		wait_idle();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (expected_walks.size() != 0) begin
			$display("%0d expected results never arrived", expected_walks.size());
			err_count++;
		end
		$display("Sent %0d items over %0d limit settings: %0d map writes, %0d wall hits,",
			items_sent, n_settings, n_writes, n_hits);
		$display("%0d rays off the map; %0d mismatches", n_left, err_count);
		if (err_count == 0) begin
			$display("PASS dda_grid_ray_walker");
		end else begin
			$display("FAIL dda_grid_ray_walker");
		end
		$finish;
	end

endmodule

### filelist.f
rtl/core/ddagw_pkg.sv
rtl/core/ddagw_map.sv
rtl/core/ddagw_walk.sv
rtl/core/dda_grid_ray_walker.sv
sim/tb_top.sv
